/* rtl/jsvm_pkg.sv */
// ----------------------------------------------------------------------------
// jsvm_pkg
// Types and constants shared by the JSON validator/minifier and its checker.
// ----------------------------------------------------------------------------
package jsvm_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       doc_last;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       doc_end;
    logic [3:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    M_VALUE     = 4'd0,
    M_ARR_FIRST = 4'd1,
    M_OBJ_FIRST = 4'd2,
    M_KEY       = 4'd3,
    M_KEYSTR    = 4'd4,
    M_COLON     = 4'd5,
    M_STR       = 4'd6,
    M_LIT       = 4'd7,
    M_NUM       = 4'd8,
    M_AFTER     = 4'd9
  } mode_t;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_EOF     = 4'd1,
    ST_CHAR    = 4'd2,
    ST_OPENSTR = 4'd3,
    ST_NUM     = 4'd4,
    ST_RANGE   = 4'd5,
    ST_KEY     = 4'd6,
    ST_COLON   = 4'd7,
    ST_OBJSEP  = 4'd8,
    ST_ARRSEP  = 4'd9,
    ST_TRAIL   = 4'd10,
    ST_DEEP    = 4'd11,
    ST_LIT     = 4'd12,
    ST_OPEN    = 4'd13
  } status_t;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // Expected character of a literal at a position (kind 0 true, 1 false, 2 null).
  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (kind)
      2'd0: begin
        unique case (pos)
          3'd0: ch = "t"; 3'd1: ch = "r"; 3'd2: ch = "u"; 3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (pos)
          3'd0: ch = "f"; 3'd1: ch = "a"; 3'd2: ch = "l"; 3'd3: ch = "s"; 3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (pos)
          3'd0: ch = "n"; 3'd1: ch = "u"; 3'd2: ch = "l"; 3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    logic [2:0] n;
    unique case (kind)
      2'd0: n = 3'd4;
      2'd1: n = 3'd5;
      2'd2: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

/* rtl/json_stream_validate_minify.sv */
// ----------------------------------------------------------------------------
// json_stream_validate_minify
// Streaming JSON syntax checker and minifier, one byte per transfer.
// ----------------------------------------------------------------------------
// Flow: a byte is registered in stage 1 with its nesting memory read, then parsed
//   once the queue has room; its results leave a small output queue one per cycle
//   while out_ready is high. Throughput: one byte per cycle while each byte yields
//   at most one result and out_ready is high; more results per byte can stall input.
// Reset: rst_n synchronous, active low; clears parser state and the queue.
//   The nesting memory is not cleared: only levels already pushed are read.
module json_stream_validate_minify #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jsvm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jsvm_pkg::out_item_t out_data
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

  // Nesting memory: one bit per level, 1 object, 0 array.
  logic nest_mem [MAX_DEPTH];

  // Stage 1 holds the accepted byte while the top-of-stack bit is read.
  logic                s1_valid_r;
  jsvm_pkg::in_item_t  s1_item_r;
  logic                top_rd_r;   // registered memory read data
  logic                fwd_sel_r;  // use forwarded top instead of memory data
  logic                fwd_bit_r;

  // Parser state.
  jsvm_pkg::mode_t mode_r;
  logic [DW-1:0]   depth_r;
  logic [1:0]      lkind_r;
  logic [2:0]      lpos_r;
  logic            neg_r, zero_r, nz_r, drop_r;
  logic [63:0]     mag_r;

  // Output queue: four entries.
  jsvm_pkg::out_item_t q_mem [4];
  logic [1:0] q_rd_r, q_wr_r;
  logic [2:0] q_cnt_r;

  // Parse combinational results.
  jsvm_pkg::mode_t mode_nxt;
  logic [DW-1:0]   depth_nxt;
  logic [1:0]      lkind_nxt;
  logic [2:0]      lpos_nxt;
  logic            neg_nxt, zero_nxt, nz_nxt, drop_nxt;
  logic [63:0]     mag_nxt;
  logic            push_en, push_bit;
  jsvm_pkg::out_item_t res [3];
  logic [1:0]      res_n;

  logic top_bit;
  logic parse_go;

  // Stage 1 may hand its byte to the parser only if the queue has room for three.
  assign parse_go = s1_valid_r && (q_cnt_r <= 3'd1 || (q_cnt_r == 3'd2 && out_valid && out_ready));
  assign in_ready = !s1_valid_r || parse_go;
  assign top_bit  = fwd_sel_r ? fwd_bit_r : top_rd_r;

  // Read the top level for the incoming byte; forward when the parsing byte
  // pushes a level in the same cycle.
  logic [DW-1:0] rd_depth;
  logic [AW-1:0] rd_addr;
  always_comb begin
    rd_depth = (s1_valid_r && parse_go) ? depth_nxt : depth_r;
    rd_addr  = (rd_depth == '0) ? '0 : AW'(rd_depth - DW'(1));
  end

  // Write a level only when its byte is consumed.
  always_ff @(posedge clk) begin
    if (parse_go && push_en) begin
      nest_mem[AW'(depth_r)] <= push_bit;
    end
    if (in_valid && in_ready) begin
      top_rd_r  <= nest_mem[rd_addr];
      s1_item_r <= in_data;
      fwd_sel_r <= parse_go && push_en;
      fwd_bit_r <= push_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Parser: one byte per cycle while the queue has room, up to three results.
  always_comb begin
    logic [7:0]  c;
    logic        last;
    logic [3:0]  st;
    logic [3:0]  d;
    logic        isdig;
    logic [63:0] lim, mag10;
    logic [2:0]  lp1;
    logic        done;
    jsvm_pkg::mode_t m;

    c = s1_item_r.in_byte;
    last = s1_item_r.doc_last;
    st = jsvm_pkg::ST_OK;
    d = c[3:0];
    isdig = (c >= "0") && (c <= "9");
    lim = 64'd0;
    mag10 = 64'd0;
    lp1 = 3'd0;
    done = 1'b0;
    m = mode_r;

    mode_nxt = mode_r; depth_nxt = depth_r; lkind_nxt = lkind_r; lpos_nxt = lpos_r;
    neg_nxt = neg_r; zero_nxt = zero_r; nz_nxt = nz_r; mag_nxt = mag_r; drop_nxt = drop_r;
    push_en = 1'b0; push_bit = 1'b0;
    res_n = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;

    if (drop_r) begin
      if (last) drop_nxt = 1'b0;
      done = 1'b1;
    end

    // Number body or termination.
    if (!done && m == jsvm_pkg::M_NUM) begin
      if (isdig) begin
        done = 1'b1;
        if (d == 4'd0 && !nz_r) begin
          zero_nxt = 1'b1;
        end else begin
          lim = neg_r ? jsvm_pkg::NEG_LIMIT : jsvm_pkg::POS_LIMIT;
          mag10 = {mag_r[60:0], 3'b000} + {mag_r[62:0], 1'b0};
          if (mag_r > 64'h1999_9999_9999_9999 || mag10 > lim - 64'(d)) begin
            st = jsvm_pkg::ST_RANGE;
          end else begin
            if (!nz_r && neg_r) begin
              res[res_n] = '{1'b1, "-", 1'b0, 4'd0}; res_n = res_n + 2'd1;
            end
            res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
            nz_nxt = 1'b1;
            mag_nxt = mag10 + 64'(d);
          end
        end
      end else if (!zero_r && !nz_r) begin
        st = jsvm_pkg::ST_NUM; done = 1'b1;
      end else begin
        if (!nz_r) begin
          res[res_n] = '{1'b1, "0", 1'b0, 4'd0}; res_n = res_n + 2'd1;
        end
        m = jsvm_pkg::M_AFTER;
        mode_nxt = jsvm_pkg::M_AFTER;
      end
    end

    if (!done) begin
      unique case (m)
        jsvm_pkg::M_VALUE, jsvm_pkg::M_ARR_FIRST, jsvm_pkg::M_AFTER,
        jsvm_pkg::M_OBJ_FIRST, jsvm_pkg::M_KEY, jsvm_pkg::M_COLON: begin
          if (jsvm_pkg::is_ws(c)) begin
            // drop
          end else if (m == jsvm_pkg::M_COLON) begin
            if (c == ":") begin
              res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
              mode_nxt = jsvm_pkg::M_VALUE;
            end else st = jsvm_pkg::ST_COLON;
          end else if (m == jsvm_pkg::M_OBJ_FIRST || m == jsvm_pkg::M_KEY) begin
            if (c == "}" && m == jsvm_pkg::M_OBJ_FIRST) begin
              res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
              depth_nxt = depth_r - DW'(1); mode_nxt = jsvm_pkg::M_AFTER;
            end else if (c == "\"") begin
              res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
              mode_nxt = jsvm_pkg::M_KEYSTR;
            end else st = jsvm_pkg::ST_KEY;
          end else if (m == jsvm_pkg::M_AFTER) begin
            if (depth_r == '0) st = jsvm_pkg::ST_TRAIL;
            else if (top_bit) begin
              if (c == ",") begin
                res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
                mode_nxt = jsvm_pkg::M_KEY;
              end else if (c == "}") begin
                res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
                depth_nxt = depth_r - DW'(1); mode_nxt = jsvm_pkg::M_AFTER;
              end else st = jsvm_pkg::ST_OBJSEP;
            end else begin
              if (c == ",") begin
                res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
                mode_nxt = jsvm_pkg::M_VALUE;
              end else if (c == "]") begin
                res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
                depth_nxt = depth_r - DW'(1); mode_nxt = jsvm_pkg::M_AFTER;
              end else st = jsvm_pkg::ST_ARRSEP;
            end
          end else if (m == jsvm_pkg::M_ARR_FIRST && c == "]") begin
            res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
            depth_nxt = depth_r - DW'(1); mode_nxt = jsvm_pkg::M_AFTER;
          end else begin
            // Start of a value.
            if (c == "\"") begin
              res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
              mode_nxt = jsvm_pkg::M_STR;
            end else if (c == "{" || c == "[") begin
              if (depth_r >= DEPTH_MAX) st = jsvm_pkg::ST_DEEP;
              else begin
                push_en = 1'b1; push_bit = (c == "{");
                depth_nxt = depth_r + DW'(1);
                res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
                mode_nxt = (c == "{") ? jsvm_pkg::M_OBJ_FIRST : jsvm_pkg::M_ARR_FIRST;
              end
            end else if (c == "t" || c == "f" || c == "n") begin
              lkind_nxt = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
              lpos_nxt = 3'd1;
              res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
              mode_nxt = jsvm_pkg::M_LIT;
            end else if (c == "-" || isdig) begin
              neg_nxt = (c == "-"); zero_nxt = 1'b0; nz_nxt = 1'b0; mag_nxt = 64'd0;
              mode_nxt = jsvm_pkg::M_NUM;
              if (isdig) begin
                if (d == 4'd0) zero_nxt = 1'b1;
                else begin
                  res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
                  nz_nxt = 1'b1; mag_nxt = 64'(d);
                end
              end
            end else st = jsvm_pkg::ST_CHAR;
          end
        end
        jsvm_pkg::M_KEYSTR, jsvm_pkg::M_STR: begin
          res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
          if (c == "\"")
            mode_nxt = (m == jsvm_pkg::M_KEYSTR) ? jsvm_pkg::M_COLON : jsvm_pkg::M_AFTER;
        end
        jsvm_pkg::M_LIT: begin
          if (lkind_r == 2'd3 || lpos_r >= jsvm_pkg::lit_len(lkind_r) ||
              c != jsvm_pkg::lit_char(lkind_r, lpos_r)) begin
            st = jsvm_pkg::ST_LIT;
          end else begin
            res[res_n] = '{1'b1, c, 1'b0, 4'd0}; res_n = res_n + 2'd1;
            lp1 = lpos_r + 3'd1;
            lpos_nxt = lp1;
            if (lp1 >= jsvm_pkg::lit_len(lkind_r)) begin
              lpos_nxt = 3'd0; mode_nxt = jsvm_pkg::M_AFTER;
            end
          end
        end
        default: st = jsvm_pkg::ST_CHAR;
      endcase
    end

    // End of document checks.
    if (!drop_r && st == jsvm_pkg::ST_OK && last) begin
      if (mode_nxt == jsvm_pkg::M_STR || mode_nxt == jsvm_pkg::M_KEYSTR) begin
        st = jsvm_pkg::ST_OPENSTR;
      end else begin
        if (mode_nxt == jsvm_pkg::M_NUM) begin
          if (!zero_nxt && !nz_nxt) st = jsvm_pkg::ST_NUM;
          else begin
            if (!nz_nxt) begin
              res[res_n] = '{1'b1, "0", 1'b0, 4'd0}; res_n = res_n + 2'd1;
            end
            mode_nxt = jsvm_pkg::M_AFTER;
          end
        end
        if (st == jsvm_pkg::ST_OK) begin
          if (mode_nxt != jsvm_pkg::M_AFTER) st = jsvm_pkg::ST_EOF;
          else if (depth_nxt != '0) st = jsvm_pkg::ST_OPEN;
        end
      end
    end

    if (!drop_r) begin
      if (st != jsvm_pkg::ST_OK) begin
        res[res_n] = '{1'b0, 8'h00, 1'b1, st}; res_n = res_n + 2'd1;
        drop_nxt = !last;
      end else if (last) begin
        if (res_n == 2'd0) begin
          res[0] = '{1'b0, 8'h00, 1'b1, 4'd0}; res_n = 2'd1;
        end else begin
          res[res_n - 2'd1].doc_end = 1'b1;
        end
      end
      if (st != jsvm_pkg::ST_OK || last) begin
        // Reset the document state.
        mode_nxt = jsvm_pkg::M_VALUE; depth_nxt = '0; lkind_nxt = 2'd0; lpos_nxt = 3'd0;
        neg_nxt = 1'b0; zero_nxt = 1'b0; nz_nxt = 1'b0; mag_nxt = 64'd0;
        push_en = 1'b0;
      end
    end else if (last) begin
      mode_nxt = jsvm_pkg::M_VALUE; depth_nxt = '0; lkind_nxt = 2'd0; lpos_nxt = 3'd0;
      neg_nxt = 1'b0; zero_nxt = 1'b0; nz_nxt = 1'b0; mag_nxt = 64'd0;
    end
  end

  // Advance the parser state only when the byte is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsvm_pkg::M_VALUE;
      depth_r <= '0; lkind_r <= 2'd0; lpos_r <= 3'd0;
      neg_r <= 1'b0; zero_r <= 1'b0; nz_r <= 1'b0; mag_r <= 64'd0; drop_r <= 1'b0;
    end else if (parse_go) begin
      mode_r <= mode_nxt;
      depth_r <= depth_nxt; lkind_r <= lkind_nxt; lpos_r <= lpos_nxt;
      neg_r <= neg_nxt; zero_r <= zero_nxt; nz_r <= nz_nxt; mag_r <= mag_nxt;
      drop_r <= drop_nxt;
    end
  end

  // Output queue.
  logic [2:0] push_n;
  logic       pop_en;
  assign push_n = parse_go ? {1'b0, res_n} : 3'd0;
  assign pop_en = out_valid && out_ready;
  assign out_valid = (q_cnt_r != 3'd0);
  assign out_data  = q_mem[q_rd_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (3'(i) < push_n) q_mem[q_wr_r + 2'(i)] <= res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_rd_r <= 2'd0; q_wr_r <= 2'd0; q_cnt_r <= 3'd0;
    end else begin
      q_wr_r <= q_wr_r + push_n[1:0];
      q_rd_r <= q_rd_r + {1'b0, pop_en};
      q_cnt_r <= q_cnt_r + push_n - {2'b00, pop_en};
    end
  end

endmodule

/* rtl/jsvm_checker.sv */
// ----------------------------------------------------------------------------
// jsvm_checker
// Port-level checks for the JSON validator/minifier.
// ----------------------------------------------------------------------------
module jsvm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input jsvm_pkg::out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Error results carry no character and always end the document.
  a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != 4'd0 |-> out_data.doc_end && !out_data.byte_valid)
    else $error("error result malformed");

  // Status never exceeds the last defined code.
  a_status_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= 4'd13)
    else $error("status out of range");

  // A result with no character is always a document end.
  a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.doc_end && out_data.out_byte == 8'd0)
    else $error("empty result without end");

  // Nothing comes out of an idle block after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind json_stream_validate_minify jsvm_checker u_jsvm_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* tb/tb_json_stream_validate_minify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_stream_validate_minify
// Streams JSON documents into the minifier and checks every emitted result
// against a behavioral parser, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_json_stream_validate_minify;

  localparam int DEPTH_LIMIT = 64;

  // Behavioral parser and queue of predicted results.
  class json_minify_scoreboard;
    jsvm_pkg::mode_t     mode;
    bit                  obj_level[DEPTH_LIMIT];
    int                  depth;
    int                  lkind;
    int                  lpos;
    bit                  neg, zero_seen, nz_seen, dropping;
    logic [63:0]         mag;
    jsvm_pkg::out_item_t pending[$];
    jsvm_pkg::out_item_t step_res[$];
    int                  errors;
    int                  docs_seen;
    int                  results_seen;

    function void clear_doc();
      mode = jsvm_pkg::M_VALUE; depth = 0; lkind = 0; lpos = 0;
      neg = 0; zero_seen = 0; nz_seen = 0; mag = '0; dropping = 0;
    endfunction

    function void put(bit v, logic [7:0] b, bit e, jsvm_pkg::status_t st);
      jsvm_pkg::out_item_t r;
      if (step_res.size() >= 3) return;
      r.byte_valid = v; r.out_byte = v ? b : 8'h00; r.doc_end = e; r.status = st;
      step_res.insert(step_res.size(), r);
    endfunction

    function bit is_space(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function logic [7:0] lit_at(int k, int p);
      string s;
      s = (k == 0) ? "true" : (k == 1) ? "false" : "null";
      return (p < s.len()) ? s[p] : 8'h00;
    endfunction

    function jsvm_pkg::status_t open_level(bit obj, logic [7:0] c);
      if (depth >= DEPTH_LIMIT) return jsvm_pkg::ST_DEEP;
      obj_level[depth] = obj; depth++;
      put(1, c, 0, jsvm_pkg::ST_OK);
      mode = obj ? jsvm_pkg::M_OBJ_FIRST : jsvm_pkg::M_ARR_FIRST;
      return jsvm_pkg::ST_OK;
    endfunction

    function void close_level(logic [7:0] c);
      if (depth > 0) depth--;
      put(1, c, 0, jsvm_pkg::ST_OK);
      mode = jsvm_pkg::M_AFTER;
    endfunction

    function jsvm_pkg::status_t digit(int d);
      logic [63:0] lim;
      if (d == 0 && !nz_seen) begin
        zero_seen = 1;
        return jsvm_pkg::ST_OK;
      end
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (mag > (lim - d) / 10) return jsvm_pkg::ST_RANGE;
      if (!nz_seen && neg) put(1, "-", 0, jsvm_pkg::ST_OK);
      put(1, 8'(48 + d), 0, jsvm_pkg::ST_OK);
      nz_seen = 1;
      mag = mag * 10 + d;
      return jsvm_pkg::ST_OK;
    endfunction

    function jsvm_pkg::status_t end_number();
      if (!zero_seen && !nz_seen) return jsvm_pkg::ST_NUM;
      if (!nz_seen) put(1, "0", 0, jsvm_pkg::ST_OK);
      mode = jsvm_pkg::M_AFTER;
      return jsvm_pkg::ST_OK;
    endfunction

    function jsvm_pkg::status_t begin_value(logic [7:0] c);
      if (c == "\"") begin
        put(1, c, 0, jsvm_pkg::ST_OK); mode = jsvm_pkg::M_STR; return jsvm_pkg::ST_OK;
      end
      if (c == "{") return open_level(1, c);
      if (c == "[") return open_level(0, c);
      if (c == "t" || c == "f" || c == "n") begin
        lkind = (c == "t") ? 0 : (c == "f") ? 1 : 2;
        lpos = 1; put(1, c, 0, jsvm_pkg::ST_OK); mode = jsvm_pkg::M_LIT;
        return jsvm_pkg::ST_OK;
      end
      if (c == "-" || (c >= "0" && c <= "9")) begin
        neg = (c == "-"); zero_seen = 0; nz_seen = 0; mag = '0; mode = jsvm_pkg::M_NUM;
        if (c != "-") return digit(c - 8'd48);
        return jsvm_pkg::ST_OK;
      end
      return jsvm_pkg::ST_CHAR;
    endfunction

    function jsvm_pkg::status_t parse_byte(logic [7:0] c);
      jsvm_pkg::status_t st;
      int n;
      if (mode == jsvm_pkg::M_NUM) begin
        if (c >= "0" && c <= "9") return digit(c - 8'd48);
        st = end_number();
        if (st != jsvm_pkg::ST_OK) return st;
      end
      case (mode)
        jsvm_pkg::M_VALUE: begin
          if (is_space(c)) return jsvm_pkg::ST_OK;
          return begin_value(c);
        end
        jsvm_pkg::M_ARR_FIRST: begin
          if (is_space(c)) return jsvm_pkg::ST_OK;
          if (c == "]") begin
            close_level(c); return jsvm_pkg::ST_OK;
          end
          return begin_value(c);
        end
        jsvm_pkg::M_OBJ_FIRST, jsvm_pkg::M_KEY: begin
          if (is_space(c)) return jsvm_pkg::ST_OK;
          if (c == "}" && mode == jsvm_pkg::M_OBJ_FIRST) begin
            close_level(c); return jsvm_pkg::ST_OK;
          end
          if (c == "\"") begin
            put(1, c, 0, jsvm_pkg::ST_OK); mode = jsvm_pkg::M_KEYSTR;
            return jsvm_pkg::ST_OK;
          end
          return jsvm_pkg::ST_KEY;
        end
        jsvm_pkg::M_KEYSTR, jsvm_pkg::M_STR: begin
          put(1, c, 0, jsvm_pkg::ST_OK);
          if (c == "\"")
            mode = (mode == jsvm_pkg::M_KEYSTR) ? jsvm_pkg::M_COLON : jsvm_pkg::M_AFTER;
          return jsvm_pkg::ST_OK;
        end
        jsvm_pkg::M_COLON: begin
          if (is_space(c)) return jsvm_pkg::ST_OK;
          if (c == ":") begin
            put(1, c, 0, jsvm_pkg::ST_OK); mode = jsvm_pkg::M_VALUE;
            return jsvm_pkg::ST_OK;
          end
          return jsvm_pkg::ST_COLON;
        end
        jsvm_pkg::M_LIT: begin
          n = (lkind == 1) ? 5 : 4;
          if (lpos >= n || c != lit_at(lkind, lpos)) return jsvm_pkg::ST_LIT;
          put(1, c, 0, jsvm_pkg::ST_OK);
          lpos++;
          if (lpos >= n) begin
            lpos = 0; mode = jsvm_pkg::M_AFTER;
          end
          return jsvm_pkg::ST_OK;
        end
        jsvm_pkg::M_AFTER: begin
          if (is_space(c)) return jsvm_pkg::ST_OK;
          if (depth == 0) return jsvm_pkg::ST_TRAIL;
          if (obj_level[depth-1]) begin
            if (c == ",") begin
              put(1, c, 0, jsvm_pkg::ST_OK); mode = jsvm_pkg::M_KEY;
              return jsvm_pkg::ST_OK;
            end
            if (c == "}") begin
              close_level(c); return jsvm_pkg::ST_OK;
            end
            return jsvm_pkg::ST_OBJSEP;
          end
          if (c == ",") begin
            put(1, c, 0, jsvm_pkg::ST_OK); mode = jsvm_pkg::M_VALUE;
            return jsvm_pkg::ST_OK;
          end
          if (c == "]") begin
            close_level(c); return jsvm_pkg::ST_OK;
          end
          return jsvm_pkg::ST_ARRSEP;
        end
        default: return jsvm_pkg::ST_CHAR;
      endcase
    endfunction

    function jsvm_pkg::status_t close_doc();
      jsvm_pkg::status_t st;
      if (mode == jsvm_pkg::M_STR || mode == jsvm_pkg::M_KEYSTR) return jsvm_pkg::ST_OPENSTR;
      if (mode == jsvm_pkg::M_NUM) begin
        st = end_number();
        if (st != jsvm_pkg::ST_OK) return st;
      end
      if (mode != jsvm_pkg::M_AFTER) return jsvm_pkg::ST_EOF;
      return (depth == 0) ? jsvm_pkg::ST_OK : jsvm_pkg::ST_OPEN;
    endfunction

    // Note one accepted input byte: predict its results.
    function void note_input(jsvm_pkg::in_item_t it);
      jsvm_pkg::status_t st;
      bit last_byte;
      last_byte = it.doc_last;
      step_res.delete();
      if (last_byte) docs_seen++;
      if (dropping) begin
        if (last_byte) clear_doc();
        return;
      end
      st = parse_byte(it.in_byte);
      if (st == jsvm_pkg::ST_OK && last_byte) st = close_doc();
      if (st != jsvm_pkg::ST_OK) begin
        put(0, 8'h00, 1, st);
        clear_doc();
        dropping = !last_byte;
      end else if (last_byte) begin
        if (step_res.size() > 0) step_res[step_res.size()-1].doc_end = 1;
        else put(0, 8'h00, 1, jsvm_pkg::ST_OK);
        clear_doc();
      end
      foreach (step_res[i]) pending.insert(pending.size(), step_res[i]);
    endfunction

    // Check one accepted result against the oldest prediction.
    function void check_result(jsvm_pkg::out_item_t got);
      jsvm_pkg::out_item_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.byte_valid !== exp.byte_valid) begin
        $display("%0t: byte_valid exp %0d got %0d", $time, exp.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.out_byte !== exp.out_byte) begin
        $display("%0t: out_byte exp %h got %h", $time, exp.out_byte, got.out_byte);
        errors++;
      end
      if (got.doc_end !== exp.doc_end) begin
        $display("%0t: doc_end exp %0d got %0d", $time, exp.doc_end, got.doc_end);
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  jsvm_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  jsvm_pkg::out_item_t out_data;

  json_minify_scoreboard sb;
  bit  calm_phase = 0;   // no idling near the end of the run
  int  bytes_sent = 0;

  // Byte source: documents are queued here, then streamed out.
  logic [7:0] doc_bytes[$];
  bit         doc_marks[$];

  always #4 clk = ~clk;

  json_stream_validate_minify #(.MAX_DEPTH(DEPTH_LIMIT)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Append a document; the last byte carries the end mark.
  task automatic add_doc(input string s);
    for (int i = 0; i < s.len(); i++) begin
      doc_bytes.insert(doc_bytes.size(), s[i]);
      doc_marks.insert(doc_marks.size(), i == s.len() - 1);
    end
  endtask

  // Drive queued bytes; hold valid and payload until each transfer.
  task automatic send_all();
    int gap;
    while (doc_bytes.size() > 0) begin
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= '{in_byte: doc_bytes[0], doc_last: doc_marks[0]};
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sb.note_input('{in_byte: doc_bytes[0], doc_last: doc_marks[0]});
      bytes_sent++;
      void'(doc_bytes.pop_front());
      void'(doc_marks.pop_front());
    end
  endtask

  // Result side: random stall bursts, check every transfer.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 8);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // One-character string.
  function automatic string char_str(logic [7:0] ch);
    string t;
    t = " ";
    t[0] = ch;
    return t;
  endfunction

  // Random document: mostly well formed, with occasional corruption.
  function automatic string rand_number();
    string s;
    int n;
    s = "";
    if ($urandom_range(0, 2) == 0) s = "-";
    case ($urandom_range(0, 5))
      0: s = {s, "000"};
      1: s = {s, "9223372036854775807"};
      2: s = {s, "9223372036854775808"};
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) s = {s, char_str(8'(48 + $urandom_range(0, 9)))};
      end
    endcase
    return s;
  endfunction

  function automatic string rand_value(int lvl);
    string s, ws;
    int n;
    ws = "";
    if ($urandom_range(0, 3) == 0) ws = " \n";
    case (lvl > 2 ? $urandom_range(0, 2) : $urandom_range(0, 4))
      0: s = rand_number();
      1: begin
        s = "\"";
        n = $urandom_range(0, 4);
        repeat (n) s = {s, char_str(8'($urandom_range(35, 126)))};
        s = {s, "\""};
      end
      2: case ($urandom_range(0, 2))
           0: s = "true";
           1: s = "false";
           default: s = "null";
         endcase
      3: begin
        s = "[";
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) s = {s, ","};
          s = {s, ws, rand_value(lvl + 1)};
        end
        s = {s, "]"};
      end
      default: begin
        s = "{";
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) s = {s, ","};
          s = {s, "\"k", char_str(8'(97 + i)), "\"", ws, ":", rand_value(lvl + 1)};
        end
        s = {s, "}"};
      end
    endcase
    return s;
  endfunction

  initial begin
    string d;
    int pos;
    sb = new();
    sb.clear_doc();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every construct, error kind and extreme.
    add_doc(" { \"a\" : [1, -0, 007, true, false, null] }\t");
    add_doc("-9223372036854775808");
    add_doc("9223372036854775808");
    add_doc("[1,]");
    add_doc("{\"a\":1,}");
    add_doc("{1:2}");
    add_doc("{\"a\" 2}");
    add_doc("{\"a\":1 2}");
    add_doc("[1 2]");
    add_doc("1 2");
    add_doc("tru");
    add_doc("trux  garbage");
    add_doc("\"open");
    add_doc("-");
    add_doc("[[");
    add_doc(" ");
    add_doc("@");
    add_doc({{64{"["}}, {64{"]"}}});
    add_doc({{65{"["}}, "x"});
    add_doc({"\"", 8'hFF, 8'h00, 8'h80, "\""});
    add_doc("-0");
    add_doc("[]");
    add_doc("{}");
    send_all();

    // Random: short well formed documents, some with one byte corrupted.
    while (bytes_sent < 470) begin
      d = rand_value(0);
      if (d.len() <= 60) begin
        if ($urandom_range(0, 3) == 0) begin
          pos = $urandom_range(0, d.len() - 1);
          d[pos] = 8'($urandom_range(0, 255));
        end
        if (bytes_sent > 400) calm_phase = 1;
        add_doc(d);
        send_all();
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d documents (%0d bytes), %0d results checked.", sb.docs_seen,
             bytes_sent, sb.results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
